// File: design/focal_length_from_svd_quadratic_unit_assert.svh
// ---------------------------------------------------------------------------
// Focal length unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef FOCAL_LENGTH_FROM_SVD_QUADRATIC_UNIT_ASSERT_SVH
`define FOCAL_LENGTH_FROM_SVD_QUADRATIC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FLSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FLSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/flsq_pkg.sv
// ---------------------------------------------------------------------------
// Focal length unit package
// Widths, codes, beat types and fixed-point helpers shared by all modules.
// ---------------------------------------------------------------------------
package flsq_pkg;

  localparam int unsigned InFracBits  = 30;
  localparam int unsigned OutFracBits = 12;
  localparam int unsigned ScaleLeft   = 2 * OutFracBits;
  localparam int unsigned ScaleRight  = InFracBits;

  localparam logic [15:0] PriorFocalReset = 16'd5000;
  localparam logic [31:0] OneQ = 32'd1 << InFracBits;

  localparam int unsigned CoefW    = 34;
  localparam int unsigned ProdW    = 2 * CoefW;
  localparam int unsigned DiscW    = ProdW + 2;
  localparam int unsigned QuotW    = 36;
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = QuotW;
  localparam int unsigned SqrtInW  = 64;
  localparam int unsigned SqrtOutW = 32;
  localparam int unsigned FifoDepth = 4;

  localparam logic [1:0] KindReal    = 2'd0;
  localparam logic [1:0] KindDouble  = 2'd1;
  localparam logic [1:0] KindComplex = 2'd2;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrNegRoot = 2'd1;
  localparam logic [1:0] ErrZeroDiv = 2'd2;

  typedef struct packed {
    logic [30:0]        sigma_first;
    logic [30:0]        sigma_second;
    logic signed [31:0] u_row3_col1;
    logic signed [31:0] u_row3_col2;
    logic signed [31:0] v_row3_col1;
    logic signed [31:0] v_row3_col2;
  } in_item_t;

  typedef struct packed {
    logic [31:0] focal_length;
    logic [1:0]  root_kind;
    logic [1:0]  error_code;
  } out_item_t;

  // Quadratic coefficients and discriminant handed from front to back.
  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
    logic [SqrtInW-1:0]      disc;
    logic [1:0]              root_kind;
  } coef_t;

  function automatic logic [31:0] clamp_u(input logic [30:0] x);
    logic [31:0] v;
    v = {1'b0, x};
    return (v > OneQ) ? OneQ : v;
  endfunction

  function automatic logic [31:0] clamp_s(input logic [31:0] x);
    logic [31:0] v;
    v = x[31] ? (~x + 32'd1) : x;
    return (v > OneQ) ? OneQ : v;
  endfunction

  // Fixed-point product, rounded to nearest with ties up.
  function automatic logic [31:0] mulr(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] p;
    p = 64'(x) * 64'(y) + (64'd1 << (InFracBits - 1));
    return p[InFracBits +: 32];
  endfunction

endpackage

// File: design/flsq_fifo.sv
// ---------------------------------------------------------------------------
// Coefficient queue
// Small register queue that decouples the front stages from the back stages.
// ---------------------------------------------------------------------------
`include "focal_length_from_svd_quadratic_unit_assert.svh"

module flsq_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = flsq_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `FLSQ_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "queue written while full")
  `FLSQ_ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o, "queue read while empty")
  `FLSQ_ASSERT_NEXT(a_push_fills, push_i && !pop_i, !empty_o, "queue lost a beat")

endmodule

// File: design/flsq_sqrt.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ---------------------------------------------------------------------------
module flsq_sqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [flsq_pkg::SqrtInW-1:0]  x_i,
  input  logic [SideW-1:0]              side_i,
  output logic                          valid_o,
  output logic [flsq_pkg::SqrtOutW-1:0] root_o,
  output logic [SideW-1:0]              side_o
);

  localparam int unsigned Stages = flsq_pkg::SqrtOutW;
  localparam int unsigned XW     = flsq_pkg::SqrtInW;

  logic           vld_s  [Stages+1];
  logic [XW-1:0]  x_s    [Stages+1];
  logic [XW-1:0]  res_s  [Stages+1];
  logic [SideW-1:0] side_s [Stages+1];

  assign vld_s[0]  = valid_i;
  assign x_s[0]    = x_i;
  assign res_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam logic [XW-1:0] Bit = XW'(1) << (2 * (Stages - 1 - i));
    logic [XW-1:0] trial;
    logic          take;

    assign trial = res_s[i] + Bit;
    assign take  = (x_s[i] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_s[i+1]    <= take ? (x_s[i] - trial) : x_s[i];
        res_s[i+1]  <= take ? ((res_s[i] >> 1) + Bit) : (res_s[i] >> 1);
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign valid_o = vld_s[Stages];
  assign root_o  = res_s[Stages][flsq_pkg::SqrtOutW-1:0];
  assign side_o  = side_s[Stages];

endmodule

// File: design/flsq_div.sv
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division of a 64-bit numerator, one quotient bit per stage.
// ---------------------------------------------------------------------------
module flsq_div #(
  parameter int unsigned SideW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [flsq_pkg::DivNumW-1:0] num_i,
  input  logic [flsq_pkg::DivDenW-1:0] den_i,
  input  logic [SideW-1:0]             side_i,
  output logic                         valid_o,
  output logic [flsq_pkg::DivNumW-1:0] quo_o,
  output logic [SideW-1:0]             side_o
);

  localparam int unsigned NW = flsq_pkg::DivNumW;
  localparam int unsigned DW = flsq_pkg::DivDenW;

  logic             vld_s  [NW+1];
  logic [NW-1:0]    num_s  [NW+1];
  logic [NW-1:0]    quo_s  [NW+1];
  logic [DW-1:0]    rem_s  [NW+1];
  logic [DW-1:0]    den_s  [NW+1];
  logic [SideW-1:0] side_s [NW+1];

  assign vld_s[0]  = valid_i;
  assign num_s[0]  = num_i;
  assign quo_s[0]  = '0;
  assign rem_s[0]  = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] trial;
    logic        take;

    assign trial = {rem_s[i], num_s[i][NW-1]};
    assign take  = (trial >= {1'b0, den_s[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[i+1]  <= take ? DW'(trial - {1'b0, den_s[i]}) : DW'(trial);
        quo_s[i+1]  <= {quo_s[i][NW-2:0], take};
        num_s[i+1]  <= num_s[i] << 1;
        den_s[i+1]  <= den_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign valid_o = vld_s[NW];
  assign quo_o   = quo_s[NW];
  assign side_o  = side_s[NW];

endmodule

// File: design/flsq_front.sv
// ---------------------------------------------------------------------------
// Coefficient front end
// Accepts input beats, clamps them and forms A, B, C and the discriminant.
// ---------------------------------------------------------------------------
module flsq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  flsq_pkg::in_item_t in_data_i,
  output logic               push_o,
  output flsq_pkg::coef_t    push_data_o,
  input  logic               full_i
);

  localparam int unsigned CW = flsq_pkg::CoefW;
  localparam int unsigned PW = flsq_pkg::ProdW;
  localparam int unsigned DW = flsq_pkg::DiscW;

  logic [6:0] v_q;
  logic       en;

  logic [31:0] a1_q, b1_q, u1_q, u2_q, v1_q, v2_q;
  logic [31:0] a2_q, b2_q, u1s_q, u2s_q, v1s_q, v2s_q;
  logic [31:0] pa_q, pb_q, ca_q, cb_q, mu_q, mv_q;
  logic [31:0] a2_3_q, b2_3_q, u1s_3_q, u2s_3_q, v1s_3_q, v2s_3_q;
  logic [31:0] ta_q, tb_q, ba_q, bb_q, tca_q, tcb_q;
  logic [31:0] sum_a, sum_b;
  logic signed [CW-1:0] ca5_q, cb5_q, cc5_q, ca6_q, cb6_q, cc6_q;
  logic signed [PW-1:0] bsq_q, ac_q;
  logic signed [DW-1:0] disc;
  flsq_pkg::coef_t      item_q;

  // The whole front advances unless its last beat waits on a full queue.
  assign en         = !(v_q[6] && full_i);
  assign in_stall_o = !en;
  assign push_o     = v_q[6] && !full_i;
  assign push_data_o = item_q;

  assign sum_a = u1s_3_q + v1s_3_q - {mu_q[30:0], 1'b0};
  assign sum_b = u2s_3_q + v2s_3_q - {mv_q[30:0], 1'b0};
  assign disc  = DW'(bsq_q) - (DW'(ac_q) <<< 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= flsq_pkg::clamp_u(in_data_i.sigma_first);
      b1_q <= flsq_pkg::clamp_u(in_data_i.sigma_second);
      u1_q <= flsq_pkg::clamp_s(in_data_i.u_row3_col1);
      u2_q <= flsq_pkg::clamp_s(in_data_i.u_row3_col2);
      v1_q <= flsq_pkg::clamp_s(in_data_i.v_row3_col1);
      v2_q <= flsq_pkg::clamp_s(in_data_i.v_row3_col2);

      a2_q  <= flsq_pkg::mulr(a1_q, a1_q);
      b2_q  <= flsq_pkg::mulr(b1_q, b1_q);
      u1s_q <= flsq_pkg::mulr(u1_q, u1_q);
      u2s_q <= flsq_pkg::mulr(u2_q, u2_q);
      v1s_q <= flsq_pkg::mulr(v1_q, v1_q);
      v2s_q <= flsq_pkg::mulr(v2_q, v2_q);

      pa_q    <= flsq_pkg::mulr(a2_q, flsq_pkg::OneQ - u1s_q);
      pb_q    <= flsq_pkg::mulr(b2_q, flsq_pkg::OneQ - u2s_q);
      ca_q    <= flsq_pkg::mulr(a2_q, u1s_q);
      cb_q    <= flsq_pkg::mulr(b2_q, u2s_q);
      mu_q    <= flsq_pkg::mulr(u1s_q, v1s_q);
      mv_q    <= flsq_pkg::mulr(u2s_q, v2s_q);
      a2_3_q  <= a2_q;
      b2_3_q  <= b2_q;
      u1s_3_q <= u1s_q;
      u2s_3_q <= u2s_q;
      v1s_3_q <= v1s_q;
      v2s_3_q <= v2s_q;

      ta_q  <= flsq_pkg::mulr(pa_q, flsq_pkg::OneQ - v1s_3_q);
      tb_q  <= flsq_pkg::mulr(pb_q, flsq_pkg::OneQ - v2s_3_q);
      ba_q  <= flsq_pkg::mulr(a2_3_q, sum_a);
      bb_q  <= flsq_pkg::mulr(b2_3_q, sum_b);
      tca_q <= flsq_pkg::mulr(ca_q, v1s_3_q);
      tcb_q <= flsq_pkg::mulr(cb_q, v2s_3_q);

      ca5_q <= $signed({2'b00, ta_q}) - $signed({2'b00, tb_q});
      cb5_q <= $signed({2'b00, ba_q}) - $signed({2'b00, bb_q});
      cc5_q <= $signed({2'b00, tca_q}) - $signed({2'b00, tcb_q});

      bsq_q <= PW'(cb5_q) * PW'(cb5_q);
      ac_q  <= PW'(ca5_q) * PW'(cc5_q);
      ca6_q <= ca5_q;
      cb6_q <= cb5_q;
      cc6_q <= cc5_q;

      item_q.coef_a <= ca6_q;
      item_q.coef_b <= cb6_q;
      item_q.coef_c <= cc6_q;
      item_q.disc   <= disc[flsq_pkg::SqrtInW-1:0];
      if (disc > 0) begin
        item_q.root_kind <= flsq_pkg::KindReal;
      end else if (disc == 0) begin
        item_q.root_kind <= flsq_pkg::KindDouble;
      end else begin
        item_q.root_kind <= flsq_pkg::KindComplex;
      end
    end
  end

endmodule

// File: design/flsq_back.sv
// ---------------------------------------------------------------------------
// Root solver back end
// Solves the quadratic, picks the larger root and scales it to a focal length.
// ---------------------------------------------------------------------------
`include "focal_length_from_svd_quadratic_unit_assert.svh"

module flsq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         pf_sq_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  flsq_pkg::coef_t     pop_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flsq_pkg::out_item_t out_data_o
);

  localparam int unsigned CW  = flsq_pkg::CoefW;
  localparam int unsigned QW  = flsq_pkg::QuotW;
  localparam int unsigned NW  = flsq_pkg::DivNumW;
  localparam int unsigned S1W = 3 * CW + 2;
  localparam int unsigned D0W = 5;

  logic en;

  // Queue output register.
  logic            v0_q;
  flsq_pkg::coef_t it0_q;

  // Discriminant root.
  logic                    sq1_valid;
  logic [31:0]             sd;
  logic [S1W-1:0]          sq1_side;
  logic signed [CW-1:0]    s_a, s_b, s_c;
  logic [1:0]              s_kind;

  logic signed [QW-1:0] b_w, sd_w, q2_w, n0_w;
  logic [1:0]           err1;
  logic                 v1_q;
  logic signed [QW-1:0] n0_q, d0_q, n1_q, d1_q;
  logic [1:0]           err1_q, kind1_q;

  logic [QW-1:0] un0, ud0, un1, ud1;
  logic          v2_q, neg0_q, neg1_q;
  logic [NW-1:0] num0_q, num1_q;
  logic [QW-1:0] den0_q, den1_q;
  logic [1:0]    err2_q, kind2_q;

  logic           d0_valid, d1_valid;
  logic [NW-1:0]  q0, q1;
  logic [D0W-1:0] d0_side;
  logic           d1_side;
  logic           s_neg0;
  logic [1:0]     s_err2, s_kind2;
  logic signed [NW-1:0] r0, r1, r_sel;

  logic                 v3_q;
  logic signed [NW-1:0] r_q;
  logic [1:0]           err3_q, kind3_q;

  logic        v4_q;
  logic [63:0] plo_q, phi_q;
  logic [1:0]  err4_q, kind4_q;

  logic [127:0] pw, px;
  logic         v5_q, sat5_q;
  logic [63:0]  x5_q;
  logic [1:0]   err5_q, kind5_q;

  logic        sq2_valid;
  logic [31:0] root;
  logic [4:0]  sq2_side;
  logic        s_sat;
  logic [1:0]  s_err5, s_kind5;

  logic                out_valid_q;
  flsq_pkg::out_item_t out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= !empty_i;
      v1_q        <= sq1_valid;
      v2_q        <= v1_q;
      v3_q        <= d0_valid && d1_valid;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= sq2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q <= pop_data_i;
    end
  end

  flsq_sqrt #(.SideW(S1W)) u_disc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .x_i     ((it0_q.root_kind == flsq_pkg::KindReal) ? it0_q.disc : '0),
    .side_i  ({it0_q.coef_a, it0_q.coef_b, it0_q.coef_c, it0_q.root_kind}),
    .valid_o (sq1_valid),
    .root_o  (sd),
    .side_o  (sq1_side)
  );

  assign {s_a, s_b, s_c, s_kind} = sq1_side;

  // Stable form: twice q is -(B + sgn(B) sqrt(D)).
  assign b_w  = QW'(s_b);
  assign sd_w = $signed({{(QW-32){1'b0}}, sd});
  assign q2_w = (s_b < 0) ? -(b_w - sd_w) : -(b_w + sd_w);
  assign n0_w = (s_kind == flsq_pkg::KindReal) ? q2_w : -b_w;
  assign err1 = ((s_a == 0) || ((s_kind == flsq_pkg::KindReal) && (q2_w == 0)))
              ? flsq_pkg::ErrZeroDiv : flsq_pkg::ErrNone;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_q    <= n0_w;
      d0_q    <= QW'(s_a) <<< 1;
      n1_q    <= QW'(s_c) <<< 1;
      d1_q    <= q2_w;
      err1_q  <= err1;
      kind1_q <= s_kind;
    end
  end

  assign un0 = n0_q[QW-1] ? QW'(-n0_q) : n0_q;
  assign ud0 = d0_q[QW-1] ? QW'(-d0_q) : d0_q;
  assign un1 = n1_q[QW-1] ? QW'(-n1_q) : n1_q;
  assign ud1 = d1_q[QW-1] ? QW'(-d1_q) : d1_q;

  // Numerator carries the fraction shift plus half the divisor for rounding.
  always_ff @(posedge clk_i) begin
    if (en) begin
      neg0_q  <= n0_q[QW-1] != d0_q[QW-1];
      neg1_q  <= n1_q[QW-1] != d1_q[QW-1];
      num0_q  <= (NW'(un0) << flsq_pkg::InFracBits) + NW'(ud0 >> 1);
      num1_q  <= (NW'(un1) << flsq_pkg::InFracBits) + NW'(ud1 >> 1);
      den0_q  <= ud0;
      den1_q  <= ud1;
      err2_q  <= err1_q;
      kind2_q <= kind1_q;
    end
  end

  flsq_div #(.SideW(D0W)) u_div_near (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num_i   (num0_q),
    .den_i   (den0_q),
    .side_i  ({neg0_q, err2_q, kind2_q}),
    .valid_o (d0_valid),
    .quo_o   (q0),
    .side_o  (d0_side)
  );

  flsq_div #(.SideW(1)) u_div_far (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num_i   (num1_q),
    .den_i   (den1_q),
    .side_i  (neg1_q),
    .valid_o (d1_valid),
    .quo_o   (q1),
    .side_o  (d1_side)
  );

  assign {s_neg0, s_err2, s_kind2} = d0_side;
  assign r0 = s_neg0  ? -$signed(q0) : $signed(q0);
  assign r1 = d1_side ? -$signed(q1) : $signed(q1);
  assign r_sel = ((s_kind2 == flsq_pkg::KindReal) && (r1 > r0)) ? r1 : r0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q     <= r_sel;
      kind3_q <= s_kind2;
      err3_q  <= ((s_err2 == flsq_pkg::ErrNone) && (r_sel < 0))
               ? flsq_pkg::ErrNegRoot : s_err2;
    end
  end

  // Root times prior focal squared, in two 32-bit halves.
  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q   <= 64'(r_q[31:0]) * 64'(pf_sq_i);
      phi_q   <= 64'(r_q[63:32]) * 64'(pf_sq_i);
      err4_q  <= err3_q;
      kind4_q <= kind3_q;
    end
  end

  assign pw = {32'd0, phi_q, 32'd0} + {64'd0, plo_q};
  assign px = (pw << flsq_pkg::ScaleLeft) >> flsq_pkg::ScaleRight;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x5_q    <= px[63:0];
      sat5_q  <= |px[127:64];
      err5_q  <= err4_q;
      kind5_q <= kind4_q;
    end
  end

  flsq_sqrt #(.SideW(5)) u_focal_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .x_i     (x5_q),
    .side_i  ({sat5_q, err5_q, kind5_q}),
    .valid_o (sq2_valid),
    .root_o  (root),
    .side_o  (sq2_side)
  );

  assign {s_sat, s_err5, s_kind5} = sq2_side;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.root_kind  <= s_kind5;
      out_q.error_code <= s_err5;
      if (s_err5 != flsq_pkg::ErrNone) begin
        out_q.focal_length <= '0;
      end else if (s_sat) begin
        out_q.focal_length <= '1;
      end else begin
        out_q.focal_length <= root;
      end
    end
  end

  `FLSQ_ASSERT_IMPL(a_div_lockstep, 1'b1, d0_valid == d1_valid, "dividers out of step")
  `FLSQ_ASSERT_IMPL(a_err_zero, out_valid_q && (out_q.error_code != flsq_pkg::ErrNone),
                    out_q.focal_length == '0, "error beat carries a focal length")
  `FLSQ_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall_i,
                    out_valid_q && $stable(out_q), "stalled output beat changed")

endmodule

// File: design/focal_length_from_svd_quadratic_unit.sv
// ---------------------------------------------------------------------------
// Focal length from SVD quadratic
// Estimates a focal length from two singular values and third-row U/V entries.
// ---------------------------------------------------------------------------
// Usage: the input channel takes one beat of unsigned Q1.30 singular values and
// signed Q2.30 U/V entries; the output channel returns one beat per input with
// the focal length in unsigned Q20.12, the root kind and an error code. A beat
// moves on a rising edge where valid is high and stall is low.
// The prior focal length is written through the configuration channel, which
// is always ready; write it only while no beats are in flight.
// The back end holds two 32-stage square root pipelines and two 64-stage
// dividers. Throughput is one beat per cycle while the output is not stalled.
// A stall on the output freezes the back end; the front keeps accepting until
// the four-entry coefficient queue and the seven front stages fill up.
// Reset clears all valid flags and loads the prior focal length with 5000.
// ---------------------------------------------------------------------------
module focal_length_from_svd_quadratic_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flsq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flsq_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned QueueW = $bits(flsq_pkg::coef_t);

  logic [15:0] prior_focal_q;
  logic [31:0] pf_sq_q;

  logic            push, full, pop, empty;
  flsq_pkg::coef_t push_data, pop_data;
  logic [QueueW-1:0] pop_vec;

  // The configuration register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_focal_q <= flsq_pkg::PriorFocalReset;
      pf_sq_q       <= 32'(flsq_pkg::PriorFocalReset) * 32'(flsq_pkg::PriorFocalReset);
    end else begin
      if (cfg_valid_i) begin
        prior_focal_q <= cfg_data_i;
      end
      // The square is registered from the prior focal length register in the next cycle.
      pf_sq_q <= 32'(prior_focal_q) * 32'(prior_focal_q);
    end
  end

  // Front end: clamp, square and form the quadratic and its discriminant.
  flsq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // The queue lets the front keep accepting while the back end is stalled.
  flsq_fifo #(.Width(QueueW), .Depth(flsq_pkg::FifoDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_vec),
    .empty_o     (empty)
  );

  assign pop_data = pop_vec;

  // Back end: roots, selection, scaling and the output register.
  flsq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pf_sq_i     (pf_sq_q),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
